### design/lfot_pkg.sv
// Shared operation and status codes for the frame order tracker.
`timescale 1ns / 1ps
`default_nettype none

package lfot_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_TOUCH   = 2'd2,
    OP_REFETCH = 2'd3
  } op_t;

  // Status codes reported with every result transaction.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned CFG_W    = 5;
  localparam int unsigned PAGE_W   = 32;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned FCOUNT_W = 5;

endpackage

`default_nettype wire

### design/lfot_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lfot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port; the read returns the old contents on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### design/lru_fifo_frame_order_tracker.sv
// An insert passes through the insert, head and response states before its result loads.
// A lookup, touch or refetch scans up to n entries, n being the fill count, since one shared
// comparator walks the order or page RAM one entry a cycle; a found move then writes the tail.
// One transaction at a time, taken the cycle after the result loads even while it waits.
// Synchronous reset (rst_n low) clears the fill count, sequencer and output valid, sets the
// capacity to 16; RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lru_fifo_frame_order_tracker #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Configuration write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [4:0]              cfg_frames_in_use,
  // Input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire lfot_pkg::op_t           in_operation,
  input  wire logic signed [31:0]      in_page_number,
  input  wire logic [3:0]              in_frame_index,
  // Result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output lfot_pkg::status_t            out_status,
  output logic [3:0]                   out_found_frame,
  output logic [3:0]                   out_lru_victim,
  output logic [3:0]                   out_fifo_oldest,
  output logic [4:0]                   out_frame_count
);

  import lfot_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_TAIL,
    S_HEAD,
    S_RESP
  } state_t;

  // Registers and their next values
  state_t                state_r,      state_nxt;
  op_t                   op_r,         op_nxt;
  logic [PAGE_W-1:0]     key_r,        key_nxt;
  logic [FIDX_W-1:0]     fidx_r,       fidx_nxt;
  logic [CNT_W-1:0]      rd_k_r,       rd_k_nxt;
  logic                  pv_r,         pv_nxt;
  logic [IDX_W-1:0]      pk_r,         pk_nxt;
  logic                  hit_r,        hit_nxt;
  logic [FIDX_W-1:0]     found_r,      found_nxt;
  status_t               status_r,     status_nxt;
  logic [CNT_W-1:0]      filled_r,     filled_nxt;
  logic [CFG_W-1:0]      cap_cfg_r,    cap_cfg_nxt;
  logic                  out_valid_r,  out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [FIDX_W-1:0]     out_found_r,  out_found_nxt;
  logic [FIDX_W-1:0]     out_lru_r,    out_lru_nxt;
  logic [FIDX_W-1:0]     out_fifo_r,   out_fifo_nxt;
  logic [FCOUNT_W-1:0]   out_count_r,  out_count_nxt;

  // RAM ports
  logic                  pg_we, lru_we, fifo_we;
  logic [IDX_W-1:0]      pg_waddr, lru_waddr, fifo_waddr;
  logic [PAGE_W-1:0]     pg_wdata;
  logic [IDX_W-1:0]      lru_wdata, fifo_wdata;
  logic [IDX_W-1:0]      rd_addr;
  logic [PAGE_W-1:0]     pg_rdata;
  logic [IDX_W-1:0]      lru_rdata, fifo_rdata;

  // Shared compare unit and scan control
  logic [IDX_W-1:0]      ord_rdata;
  logic [PAGE_W-1:0]     cmp_data;
  logic                  cmp_eq;
  logic                  scan_more;
  logic                  lookup_stop;
  logic [CMP_W-1:0]      cap_eff;
  logic                  pool_full;

  lfot_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (rd_addr),
    .rdata (pg_rdata)
  );

  lfot_ram #(.WIDTH(IDX_W), .DEPTH(MAX_FRAMES)) u_lru_ram (
    .clk   (clk),
    .we    (lru_we),
    .waddr (lru_waddr),
    .wdata (lru_wdata),
    .raddr (rd_addr),
    .rdata (lru_rdata)
  );

  lfot_ram #(.WIDTH(IDX_W), .DEPTH(MAX_FRAMES)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (rd_addr),
    .rdata (fifo_rdata)
  );

  // Handshake outputs
  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_frame = out_found_r;
  assign out_lru_victim  = out_lru_r;
  assign out_fifo_oldest = out_fifo_r;
  assign out_frame_count = out_count_r;

  // Effective capacity: zero acts as one, values above the pool size are clamped.
  always_comb begin
    if (cap_cfg_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_cfg_r) > CMP_W'(MAX_FRAMES)) begin
      cap_eff = CMP_W'(MAX_FRAMES);
    end else begin
      cap_eff = CMP_W'(cap_cfg_r);
    end
  end
  assign pool_full = (CMP_W'(filled_r) >= cap_eff);

  // Reads walk the scan counter; the head states read entry zero of both order lists.
  assign rd_addr = ((state_r == S_HEAD) || (state_r == S_RESP)) ? '0 : rd_k_r[IDX_W-1:0];

  // The comparator sees the page RAM for lookups and the selected order list otherwise.
  assign ord_rdata = (op_r == OP_TOUCH) ? lru_rdata : fifo_rdata;
  assign cmp_data  = (op_r == OP_LOOKUP) ? pg_rdata : PAGE_W'(ord_rdata);
  assign cmp_eq    = (cmp_data == key_r);
  assign scan_more = (rd_k_r < filled_r);

  // Sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    fidx_nxt       = fidx_r;
    rd_k_nxt       = rd_k_r;
    pv_nxt         = pv_r;
    pk_nxt         = pk_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    filled_nxt     = filled_r;
    cap_cfg_nxt    = cap_cfg_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_lru_nxt    = out_lru_r;
    out_fifo_nxt   = out_fifo_r;
    out_count_nxt  = out_count_r;
    lookup_stop    = 1'b0;

    pg_we      = 1'b0;
    lru_we     = 1'b0;
    fifo_we    = 1'b0;
    pg_waddr   = filled_r[IDX_W-1:0];
    pg_wdata   = key_r;
    lru_waddr  = filled_r[IDX_W-1:0];
    lru_wdata  = filled_r[IDX_W-1:0];
    fifo_waddr = filled_r[IDX_W-1:0];
    fifo_wdata = filled_r[IDX_W-1:0];

    if (cfg_valid && cfg_ready) begin
      cap_cfg_nxt = cfg_frames_in_use;
    end

    // A taken result frees the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          fidx_nxt  = in_frame_index;
          rd_k_nxt  = '0;
          pv_nxt    = 1'b0;
          hit_nxt   = 1'b0;
          found_nxt = '0;
          case (in_operation)
            OP_INSERT: begin
              key_nxt    = in_page_number;
              status_nxt = ST_OK;
              state_nxt  = S_INS;
            end
            OP_LOOKUP: begin
              key_nxt    = in_page_number;
              status_nxt = ST_NOTFOUND;
              state_nxt  = S_SCAN;
            end
            default: begin
              key_nxt   = PAGE_W'(in_frame_index);
              found_nxt = in_frame_index;
              if (filled_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_HEAD;
              end else begin
                status_nxt = ST_OK;
                state_nxt  = S_SCAN;
              end
            end
          endcase
        end
      end

      // Append the new frame to the page table and both order lists.
      S_INS: begin
        if (pool_full) begin
          status_nxt = ST_FULL;
          found_nxt  = '0;
        end else begin
          pg_we      = 1'b1;
          lru_we     = 1'b1;
          fifo_we    = 1'b1;
          found_nxt  = FIDX_W'(filled_r);
          filled_nxt = filled_r + 1'b1;
        end
        state_nxt = S_HEAD;
      end

      // One entry per cycle: compare, and for moves shift later entries down by one.
      S_SCAN: begin
        if (pv_r && cmp_eq && !hit_r) begin
          hit_nxt = 1'b1;
          if (op_r == OP_LOOKUP) begin
            found_nxt   = FIDX_W'(pk_r);
            status_nxt  = ST_OK;
            lookup_stop = 1'b1;
          end
        end
        if (pv_r && hit_r && (op_r != OP_LOOKUP)) begin
          if (op_r == OP_TOUCH) begin
            lru_we    = 1'b1;
            lru_waddr = IDX_W'(pk_r - 1'b1);
            lru_wdata = ord_rdata;
          end else begin
            fifo_we    = 1'b1;
            fifo_waddr = IDX_W'(pk_r - 1'b1);
            fifo_wdata = ord_rdata;
          end
        end
        if (scan_more && !lookup_stop) begin
          rd_k_nxt = rd_k_r + 1'b1;
          pv_nxt   = 1'b1;
          pk_nxt   = rd_k_r[IDX_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (!scan_more || lookup_stop) begin
          if ((op_r != OP_LOOKUP) && hit_nxt) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end

      // Place the moved frame at the tail of its list.
      S_TAIL: begin
        if (op_r == OP_TOUCH) begin
          lru_we    = 1'b1;
          lru_waddr = IDX_W'(filled_r - 1'b1);
          lru_wdata = IDX_W'(fidx_r);
        end else begin
          fifo_we    = 1'b1;
          fifo_waddr = IDX_W'(filled_r - 1'b1);
          fifo_wdata = IDX_W'(fidx_r);
        end
        state_nxt = S_HEAD;
      end

      S_HEAD: begin
        state_nxt = S_RESP;
      end

      // Load the result register once it is free.
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_lru_nxt    = (filled_r != '0) ? FIDX_W'(lru_rdata) : '0;
          out_fifo_nxt   = (filled_r != '0) ? FIDX_W'(fifo_rdata) : '0;
          out_count_nxt  = FCOUNT_W'(filled_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= 1'b0;
      hit_r       <= 1'b0;
      filled_r    <= '0;
      cap_cfg_r   <= CFG_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      hit_r       <= hit_nxt;
      filled_r    <= filled_nxt;
      cap_cfg_r   <= cap_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    fidx_r       <= fidx_nxt;
    rd_k_r       <= rd_k_nxt;
    pk_r         <= pk_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_lru_r    <= out_lru_nxt;
    out_fifo_r   <= out_fifo_nxt;
    out_count_r  <= out_count_nxt;
  end

  // The fill count never passes the pool size.
  assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(MAX_FRAMES))
    else $error("fill count above pool size");

  // The fill count only ever grows by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (filled_r != $past(filled_r)) |-> (filled_r == CNT_W'($past(filled_r) + 1'b1)))
    else $error("fill count changed by other than one");

  // No RAM is written while the sequencer is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pg_we && !lru_we && !fifo_we))
    else $error("RAM write while idle");

  // A full pool reports frame zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_found_r == '0))
    else $error("full status with nonzero frame");

  // An empty pool reports zero for both victims.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r == '0)) |-> ((out_lru_r == '0) && (out_fifo_r == '0)))
    else $error("empty pool with nonzero victim");

endmodule

`default_nettype wire
